### src/ose_pkg.sv
// Shared types and constants for the odometry speed estimator.
`timescale 1ns / 1ps
package ose_pkg;

  localparam logic [31:0] NS_PER_SEC = 32'd1000000000;
  localparam logic [31:0] MAX32      = 32'hFFFF_FFFF;
  localparam int          CNT_W      = 5;
  localparam logic [CNT_W-1:0] STEP_LAST = 5'd31;  // last of 32 one-bit steps
  localparam logic [CNT_W-1:0] SQ_LAST   = 5'd3;   // last square/accumulate cycle

  typedef enum logic [1:0] {
    MUL_X   = 2'd0,
    MUL_Y   = 2'd1,
    MUL_Z   = 2'd2,
    MUL_NUM = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_add;
    logic     rt_step;
    logic     diff_en;
    logic     div_init;
    logic     div_step;
    logic     out_load;
  } ose_cmd_t;

  typedef struct packed {
    logic zero;
    logic ovf;
  } ose_sts_t;

endpackage

### src/ose_if.sv
// Handshake channels for odometry samples and speed results.
`timescale 1ns / 1ps
interface ose_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [31:0]        stamp_sec;
  logic [29:0]        stamp_nsec;

  modport source(output valid, pos_x, pos_y, pos_z, stamp_sec, stamp_nsec, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, stamp_sec, stamp_nsec, output ready);
endinterface

interface ose_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] speed;
  logic [31:0] distance_change;
  logic [31:0] elapsed_ns;
  logic        zero_time;

  modport source(output valid, speed, distance_change, elapsed_ns, zero_time, input ready);
  modport sink(input valid, speed, distance_change, elapsed_ns, zero_time, output ready);
endinterface

### src/ose_dp.sv
// Datapath: magnitudes, shared multiplier, bit-serial square root and divider, history.
`timescale 1ns / 1ps
module ose_dp #(
  parameter int WINDOW = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  input  logic [31:0]         stamp_sec,
  input  logic [29:0]         stamp_nsec,
  input  ose_pkg::ose_cmd_t   cmd,
  output ose_pkg::ose_sts_t   sts,
  output logic [31:0]         speed,
  output logic [31:0]         distance_change,
  output logic [31:0]         elapsed_ns,
  output logic                zero_time
);

  localparam int DEPTH = WINDOW - 1;

  logic [31:0] mag_x, mag_y, mag_z;
  logic [31:0] sec;
  logic [29:0] nsec;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [33:0] rem;
  logic [35:0] rt_r2, rt_trial;
  logic [31:0] root;
  logic [31:0] ddist;
  logic [31:0] elapsed;
  logic        zero;
  logic [31:0] dist_hist [DEPTH];
  logic [31:0] sec_hist  [DEPTH];
  logic [29:0] nsec_hist [DEPTH];
  logic [31:0] ddist_next, elapsed_next;
  logic [31:0] drem;
  logic [32:0] div_r2;
  logic [31:0] quo;
  logic        sat;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  // Operand select for the shared multiplier.
  always_comb begin
    unique case (cmd.mul_sel)
      ose_pkg::MUL_X:   begin mul_a = mag_x; mul_b = mag_x; end
      ose_pkg::MUL_Y:   begin mul_a = mag_y; mul_b = mag_y; end
      ose_pkg::MUL_Z:   begin mul_a = mag_z; mul_b = mag_z; end
      ose_pkg::MUL_NUM: begin mul_a = ddist; mul_b = ose_pkg::NS_PER_SEC; end
      default:          begin mul_a = ddist; mul_b = ose_pkg::NS_PER_SEC; end
    endcase
  end

  assign rt_r2    = {rem, acc[63:62]};
  assign rt_trial = {2'b00, root, 2'b01};

  assign ddist_next = (root > dist_hist[0]) ? root - dist_hist[0] : dist_hist[0] - root;
  assign elapsed_next = (sec == sec_hist[0])
                      ? {2'b00, nsec} - {2'b00, nsec_hist[0]}
                      : {2'b00, nsec} + ose_pkg::NS_PER_SEC - {2'b00, nsec_hist[0]};

  assign div_r2 = {drem, quo[31]};

  assign sts.zero = zero;
  assign sts.ovf  = prod[63:32] >= elapsed;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_x <= mag32(pos_x);
      mag_y <= mag32(pos_y);
      mag_z <= mag32(pos_z);
      sec   <= stamp_sec;
      nsec  <= stamp_nsec;
    end
    if (cmd.mul_en) begin
      prod <= 64'(mul_a) * 64'(mul_b);
    end
    if (cmd.load) begin
      acc  <= '0;
      rem  <= '0;
      root <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc + prod;
    end else if (cmd.rt_step) begin
      // Bring in two radicand bits, keep a one when the trial fits.
      acc <= {acc[61:0], 2'b00};
      if (rt_r2 >= rt_trial) begin
        rem  <= 34'(rt_r2 - rt_trial);
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= rt_r2[33:0];
        root <= {root[30:0], 1'b0};
      end
    end
    if (cmd.diff_en) begin
      ddist   <= ddist_next;
      elapsed <= elapsed_next;
      zero    <= (elapsed_next == '0);
    end
    if (cmd.div_init) begin
      drem <= prod[63:32];
      quo  <= prod[31:0];
      sat  <= zero | sts.ovf;
    end else if (cmd.div_step) begin
      if (div_r2 >= {1'b0, elapsed}) begin
        drem <= 32'(div_r2 - {1'b0, elapsed});
        quo  <= {quo[30:0], 1'b1};
      end else begin
        drem <= div_r2[31:0];
        quo  <= {quo[30:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      speed           <= sat ? ose_pkg::MAX32 : quo;
      distance_change <= ddist;
      elapsed_ns      <= elapsed;
      zero_time       <= zero;
    end
  end

  // Window history, entry 0 oldest; advance once per item.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        dist_hist[i] <= '0;
        sec_hist[i]  <= '0;
        nsec_hist[i] <= '0;
      end
    end else if (cmd.diff_en) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        dist_hist[i] <= dist_hist[i+1];
        sec_hist[i]  <= sec_hist[i+1];
        nsec_hist[i] <= nsec_hist[i+1];
      end
      dist_hist[DEPTH-1] <= root;
      sec_hist[DEPTH-1]  <= sec;
      nsec_hist[DEPTH-1] <= nsec;
    end
  end

endmodule

### src/ose_ctrl.sv
// Controller: sequences squares, root, difference, scaling and, unless the speed saturates, division per item.
`timescale 1ns / 1ps
module ose_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ose_pkg::ose_sts_t sts,
  output ose_pkg::ose_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SQ   = 8'b0000_0010,
    S_RT   = 8'b0000_0100,
    S_DIFF = 8'b0000_1000,
    S_NUM  = 8'b0001_0000,
    S_CHK  = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  state_t                    state, state_next;
  logic [ose_pkg::CNT_W-1:0] cnt, cnt_next;
  logic                      out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    cnt_next     = '0;
    cmd          = '0;
    cmd.mul_sel  = ose_pkg::MUL_NUM;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.mul_en  = (cnt != ose_pkg::SQ_LAST);
        cmd.acc_add = (cnt != '0);
        unique case (cnt[1:0])
          2'd0:    cmd.mul_sel = ose_pkg::MUL_X;
          2'd1:    cmd.mul_sel = ose_pkg::MUL_Y;
          default: cmd.mul_sel = ose_pkg::MUL_Z;
        endcase
        if (cnt == ose_pkg::SQ_LAST) begin
          state_next = S_RT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_RT: begin
        cmd.rt_step = 1'b1;
        if (cnt == ose_pkg::STEP_LAST) begin
          state_next = S_DIFF;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DIFF: begin
        cmd.diff_en = 1'b1;
        state_next  = S_NUM;
      end
      S_NUM: begin
        cmd.mul_en = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.div_init = 1'b1;
        // Skip the divide when the result saturates anyway.
        state_next   = (sts.zero || sts.ovf) ? S_FIN : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == ose_pkg::STEP_LAST) begin
          state_next = S_FIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_SQ))
    else $error("accepted item did not start the square phase");

  a_root_to_diff: assert property (@(posedge clk) disable iff (rst)
    (state == S_RT && cnt == ose_pkg::STEP_LAST) |=> (state == S_DIFF))
    else $error("root did not finish after its last step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register loaded while a result waits");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

  a_div_unsat: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> !sts.zero)
    else $error("divide running with zero elapsed time");

endmodule

### src/odometry_speed_estimator.sv
// Top level of the odometry speed estimator.
//
//  channel  | dir | payload
//  ---------+-----+---------------------------------------------------------
//  sample   | in  | pos_x, pos_y, pos_z (Q16.16), stamp_sec, stamp_nsec
//  result   | out | speed (Q16.16 m/s), distance_change, elapsed_ns, zero_time
//
// One item at a time: the next item is accepted only back in idle, after the squares,
// the 32 root steps and, unless the speed saturates or the elapsed time is zero, the
// 32 divide steps; the bit-serial root and divider set the pace.
// A finished result waits in the output register; the next item is taken while
// it waits, and the block holds in its final state only if a second result is
// ready before the first is taken. Synchronous reset clears the window history.
`timescale 1ns / 1ps
module odometry_speed_estimator #(
  parameter int WINDOW = 6
) (
  input  logic         clk,
  input  logic         rst,
  ose_sample_if.sink   sample,
  ose_result_if.source result
);

  ose_pkg::ose_cmd_t cmd;
  ose_pkg::ose_sts_t sts;

  ose_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ose_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .pos_x           (sample.pos_x),
    .pos_y           (sample.pos_y),
    .pos_z           (sample.pos_z),
    .stamp_sec       (sample.stamp_sec),
    .stamp_nsec      (sample.stamp_nsec),
    .cmd             (cmd),
    .sts             (sts),
    .speed           (result.speed),
    .distance_change (result.distance_change),
    .elapsed_ns      (result.elapsed_ns),
    .zero_time       (result.zero_time)
  );

endmodule
